/* src/rsd_pkg.sv */
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants of the run-length symbol decoder: decoder
// phases, status codes, the archive signature and the result record.
// ----------------------------------------------------------------------------
package rsd_pkg;

   localparam int unsigned SIG_LEN = 9;
   localparam logic [7:0] RUN_FLAG = 8'h80;
   localparam logic [7:0] RAW_CODE = 8'd128;
   localparam logic [7:0] SKIP_CODE = 8'd0;

   typedef enum logic [5:0] {
      PH_HEADER    = 6'b000001,
      PH_SIGNATURE = 6'b000010,
      PH_CODE      = 6'b000100,
      PH_SYMBOL    = 6'b001000,
      PH_RAW       = 6'b010000,
      PH_IDLE      = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      ST_DATA     = 2'd0,
      ST_BAD_SIZE = 2'd1,
      ST_BAD_SIG  = 2'd2
   } status_type;

   typedef struct packed {
      logic [63:0] symbol_data;
      logic [3:0]  byte_count;
      logic [6:0]  repeat_count;
      status_type  status;
   } result_type;

   // "rlev.1.1" followed by a newline
   function automatic logic [7:0] sig_byte(input logic [3:0] idx);
      logic [7:0] val;
      case (idx)
         4'd0:    val = 8'h72;
         4'd1:    val = 8'h6C;
         4'd2:    val = 8'h65;
         4'd3:    val = 8'h76;
         4'd4:    val = 8'h2E;
         4'd5:    val = 8'h31;
         4'd6:    val = 8'h2E;
         4'd7:    val = 8'h31;
         4'd8:    val = 8'h0A;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

/* src/rsd_core.sv */
// ----------------------------------------------------------------------------
// rsd_core
// Decoder state and the per-byte decode step. Presents the result of the
// held byte combinationally and commits the state update on step.
// ----------------------------------------------------------------------------
module rsd_core #(
   parameter int unsigned MAX_SYMBOL_BYTES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic                stream_start,
   output logic                emit,
   output rsd_pkg::result_type result
);

   localparam int unsigned IDX_W = (MAX_SYMBOL_BYTES > 1) ? $clog2(MAX_SYMBOL_BYTES) : 1;
   localparam int unsigned BUF_W = 8 * MAX_SYMBOL_BYTES;

   rsd_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [3:0]        size_ff, size_in;
   logic [3:0]        sig_idx_ff, sig_idx_in;
   logic              sig_bad_ff, sig_bad_in;
   logic [IDX_W-1:0]  byte_idx_ff, byte_idx_in;
   logic [BUF_W-1:0]  buf_ff, buf_in, buf_fill;
   logic [6:0]        run_ff, run_in;
   logic              rep_mode_ff, rep_mode_in;
   logic [3:0]        byte_cnt_next;
   logic [3:0]        sig_idx_next;
   logic              sig_bad_next;

   always_comb begin
      for (int i = 0; i < MAX_SYMBOL_BYTES; i++) begin
         buf_fill[i*8 +: 8] = (byte_idx_ff == IDX_W'(i)) ? data_byte : buf_ff[i*8 +: 8];
      end
   end

   assign byte_cnt_next = 4'(byte_idx_ff) + 4'd1;
   assign sig_idx_next  = sig_idx_ff + 4'd1;
   assign sig_bad_next  = sig_bad_ff || (data_byte != rsd_pkg::sig_byte(sig_idx_ff));

   always_comb begin
      phase_cur   = stream_start ? rsd_pkg::PH_HEADER : phase_ff;
      phase_in    = phase_cur;
      size_in     = size_ff;
      sig_idx_in  = sig_idx_ff;
      sig_bad_in  = sig_bad_ff;
      byte_idx_in = byte_idx_ff;
      buf_in      = buf_ff;
      run_in      = run_ff;
      rep_mode_in = rep_mode_ff;
      emit        = 1'b0;
      result      = '{symbol_data: 64'd0, byte_count: 4'd0, repeat_count: 7'd0,
                      status: rsd_pkg::ST_DATA};
      case (phase_cur)
         rsd_pkg::PH_HEADER: begin
            if (data_byte == 8'd0 || data_byte > 8'(MAX_SYMBOL_BYTES)) begin
               phase_in      = rsd_pkg::PH_IDLE;
               emit          = 1'b1;
               result.status = rsd_pkg::ST_BAD_SIZE;
            end else begin
               size_in    = data_byte[3:0];
               sig_idx_in = 4'd0;
               sig_bad_in = 1'b0;
               phase_in   = rsd_pkg::PH_SIGNATURE;
            end
         end
         rsd_pkg::PH_SIGNATURE: begin
            sig_idx_in = sig_idx_next;
            sig_bad_in = sig_bad_next;
            if (sig_idx_next >= 4'(rsd_pkg::SIG_LEN)) begin
               if (sig_bad_next) begin
                  phase_in      = rsd_pkg::PH_IDLE;
                  emit          = 1'b1;
                  result.status = rsd_pkg::ST_BAD_SIG;
               end else begin
                  phase_in = rsd_pkg::PH_CODE;
               end
            end
         end
         rsd_pkg::PH_CODE: begin
            if (data_byte == rsd_pkg::RAW_CODE) begin
               phase_in = rsd_pkg::PH_RAW;
            end else if (data_byte != rsd_pkg::SKIP_CODE) begin
               rep_mode_in = (data_byte & rsd_pkg::RUN_FLAG) != 8'd0;
               run_in      = data_byte[6:0];
               byte_idx_in = '0;
               buf_in      = '0;
               phase_in    = rsd_pkg::PH_SYMBOL;
            end
         end
         rsd_pkg::PH_SYMBOL: begin
            if (byte_cnt_next < size_ff) begin
               byte_idx_in = byte_idx_ff + IDX_W'(1);
               buf_in      = buf_fill;
            end else begin
               emit                = 1'b1;
               result.symbol_data  = 64'(buf_fill);
               result.byte_count   = size_ff;
               result.repeat_count = rep_mode_ff ? run_ff : 7'd1;
               buf_in              = '0;
               byte_idx_in         = '0;
               if (rep_mode_ff) begin
                  phase_in = rsd_pkg::PH_CODE;
               end else begin
                  run_in = run_ff - 7'd1;
                  if (run_ff == 7'd1) begin
                     phase_in = rsd_pkg::PH_CODE;
                  end
               end
            end
         end
         rsd_pkg::PH_RAW: begin
            emit                = 1'b1;
            result.symbol_data  = {56'd0, data_byte};
            result.byte_count   = 4'd1;
            result.repeat_count = 7'd1;
         end
         default: begin
            phase_in = phase_cur;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= rsd_pkg::PH_HEADER;
         size_ff     <= 4'd0;
         sig_idx_ff  <= 4'd0;
         sig_bad_ff  <= 1'b0;
         byte_idx_ff <= '0;
         run_ff      <= 7'd0;
         rep_mode_ff <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         size_ff     <= size_in;
         sig_idx_ff  <= sig_idx_in;
         sig_bad_ff  <= sig_bad_in;
         byte_idx_ff <= byte_idx_in;
         run_ff      <= run_in;
         rep_mode_ff <= rep_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         buf_ff <= buf_in;
      end
   end

endmodule

/* src/rle_symbol_decoder_unit.sv */
// ----------------------------------------------------------------------------
// rle_symbol_decoder_unit
// Run-length decoder for a byte-stream archive: header, signature check,
// run and literal codes, raw copy.
// ----------------------------------------------------------------------------
// Takes one archive byte per cycle while the request register is not
// stalled. Each request is registered, decoded by the core against the
// decoder state, and any symbol or status it produces lands in the result
// register. The single result register sets the limit under backpressure:
// while a result is stalled, bytes that produce no result still advance,
// and the first byte that would produce one holds in the request register
// until the result slot frees.
module rle_symbol_decoder_unit #(
   parameter int unsigned MAX_SYMBOL_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_symbol_data,
   output logic [3:0]  rsp_byte_count,
   output logic [6:0]  rsp_repeat_count,
   output logic [1:0]  rsp_status
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_start_ff;
   logic                res_valid_ff, res_valid_in;
   rsd_pkg::result_type res_ff;
   rsd_pkg::result_type core_result;
   logic                core_emit;
   logic                step;
   logic                req_take;

   assign step      = in_valid_ff && (!core_emit || !res_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      res_valid_in = res_valid_ff;
      if (step && core_emit) begin
         res_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         res_valid_in = 1'b0;
      end
   end

   rsd_core #(
      .MAX_SYMBOL_BYTES(MAX_SYMBOL_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (in_byte_ff),
      .stream_start(in_start_ff),
      .emit        (core_emit),
      .result      (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_stream_start;
      end
      if (step && core_emit) begin
         res_ff <= core_result;
      end
   end

   assign rsp_valid        = res_valid_ff;
   assign rsp_symbol_data  = res_ff.symbol_data;
   assign rsp_byte_count   = res_ff.byte_count;
   assign rsp_repeat_count = res_ff.repeat_count;
   assign rsp_status       = res_ff.status;

endmodule

/* bench/rle_symbol_decoder_unit_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_symbol_decoder_unit_checker
// Watches the request and result channels of the run-length symbol decoder.
// It decodes every accepted archive byte in its own model of the decoder,
// queues the symbol or status result that byte should produce, and checks
// each accepted result field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module rle_symbol_decoder_unit_checker #(
   parameter int unsigned MAX_SYMBOL_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_start,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_symbol_data,
   input  logic [3:0]  rsp_byte_count,
   input  logic [6:0]  rsp_repeat_count,
   input  logic [1:0]  rsp_status,
   output int          mismatch_count,
   output int          pending_count,
   output int          symbol_count,
   output int          status_count
);

   import rsd_pkg::*;

   localparam logic [71:0] SIGNATURE = "rlev.1.1\n";
   localparam int REPORT_LIMIT = 10;

   phase_type   phase;
   logic [3:0]  size_reg;
   logic [3:0]  sig_pos;
   logic        sig_bad;
   logic [3:0]  fill_pos;
   logic [63:0] symbol_acc;
   logic [6:0]  run_left;
   logic        run_mode;
   result_type  expected_symbols[$];

   task automatic clear_decoder();
      phase = PH_HEADER;
      size_reg = '0;
      sig_pos = '0;
      sig_bad = 1'b0;
      fill_pos = '0;
      symbol_acc = '0;
      run_left = '0;
      run_mode = 1'b0;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic start,
                              output logic emitted, output result_type r);
      emitted = 1'b0;
      r = '0;
      if (start)
         clear_decoder();
      case (phase)
         PH_HEADER: begin
            if (b == 8'd0 || b > MAX_SYMBOL_BYTES) begin
               phase = PH_IDLE;
               r.status = ST_BAD_SIZE;
               emitted = 1'b1;
            end else begin
               size_reg = b[3:0];
               sig_pos = '0;
               sig_bad = 1'b0;
               phase = PH_SIGNATURE;
            end
         end
         PH_SIGNATURE: begin
            if (sig_pos < SIG_LEN && b != SIGNATURE[71 - 8 * sig_pos -: 8])
               sig_bad = 1'b1;
            sig_pos = sig_pos + 4'd1;
            if (sig_pos >= SIG_LEN) begin
               if (sig_bad) begin
                  phase = PH_IDLE;
                  r.status = ST_BAD_SIG;
                  emitted = 1'b1;
               end else begin
                  phase = PH_CODE;
               end
            end
         end
         PH_CODE: begin
            if (b == RAW_CODE) begin
               phase = PH_RAW;
            end else if (b != SKIP_CODE) begin
               run_mode = (b & RUN_FLAG) != 8'd0;
               run_left = b[6:0];
               fill_pos = '0;
               symbol_acc = '0;
               phase = PH_SYMBOL;
            end
         end
         PH_SYMBOL: begin
            symbol_acc = symbol_acc | (64'(b) << (8 * fill_pos[2:0]));
            fill_pos = fill_pos + 4'd1;
            if (fill_pos >= size_reg) begin
               r.symbol_data = symbol_acc;
               r.byte_count = size_reg;
               r.repeat_count = run_mode ? run_left : 7'd1;
               r.status = ST_DATA;
               emitted = 1'b1;
               symbol_acc = '0;
               fill_pos = '0;
               if (run_mode) begin
                  phase = PH_CODE;
               end else begin
                  run_left = run_left - 7'd1;
                  if (run_left == 7'd0)
                     phase = PH_CODE;
               end
            end
         end
         PH_RAW: begin
            r.symbol_data = {56'd0, b};
            r.byte_count = 4'd1;
            r.repeat_count = 7'd1;
            r.status = ST_DATA;
            emitted = 1'b1;
         end
         default: ;
      endcase
   endtask

   task automatic report_failure(input string what, input result_type want,
                                 input result_type seen);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t %s: expected data %h bytes %0d repeat %0d status %0d",
                  $time, what, want.symbol_data, want.byte_count, want.repeat_count,
                  want.status);
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t %s:      got data %h bytes %0d repeat %0d status %0d",
                  $time, what, seen.symbol_data, seen.byte_count, seen.repeat_count,
                  seen.status);
   endtask

   always @(posedge clock) begin : watch
      logic       emitted;
      result_type want_r;
      result_type seen_r;
      if (reset) begin
         clear_decoder();
         expected_symbols.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_r.symbol_data = rsp_symbol_data;
            seen_r.byte_count = rsp_byte_count;
            seen_r.repeat_count = rsp_repeat_count;
            seen_r.status = status_type'(rsp_status);
            if (expected_symbols.size() == 0) begin
               report_failure("unexpected result", '0, seen_r);
            end else begin
               want_r = expected_symbols.pop_front();
               if (seen_r.symbol_data !== want_r.symbol_data ||
                   seen_r.byte_count !== want_r.byte_count ||
                   seen_r.repeat_count !== want_r.repeat_count ||
                   seen_r.status !== want_r.status)
                  report_failure("result mismatch", want_r, seen_r);
               if (want_r.status == ST_DATA)
                  symbol_count++;
               else
                  status_count++;
            end
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_data_byte, req_stream_start, emitted, want_r);
            if (emitted)
               expected_symbols.push_back(want_r);
         end
      end
      pending_count = expected_symbols.size();
   end

endmodule

/* bench/rle_symbol_decoder_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_symbol_decoder_unit_tb
// Feeds the run-length symbol decoder with archives: a short directed
// opening, then mostly well-formed archives with random sizes, codes and
// symbols, mixed with bad headers, broken signatures, cut-off symbols and
// noise. Sender bursts and receiver stalls vary; one long receiver hold-off
// backs the decoder up. A checker module predicts and compares the results.
// ----------------------------------------------------------------------------
module rle_symbol_decoder_unit_tb;

   import rsd_pkg::*;

   localparam int unsigned MAX_BYTES = 8;
   localparam int RANDOM_BYTES = 1400;
   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD = 200;
   localparam int DRAIN_CYCLES = 10;

   typedef enum int {
      HOLD_NONE,
      HOLD_RANDOM,
      HOLD_PERIODIC,
      HOLD_BURSTS
   } stall_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_stream_start;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_symbol_data;
   logic [3:0]  rsp_byte_count;
   logic [6:0]  rsp_repeat_count;
   logic [1:0]  rsp_status;

   int mismatch_count;
   int pending_count;
   int symbol_count;
   int status_count;
   int live_bytes = 0;
   int archive_count = 0;
   int burst_left = 0;
   int quiet_cycles = 0;
   bit want_long_hold = 1'b0;
   bit long_hold_done = 1'b0;

   rle_symbol_decoder_unit #(
      .MAX_SYMBOL_BYTES(MAX_BYTES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_stream_start(req_stream_start),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_symbol_data(rsp_symbol_data),
      .rsp_byte_count(rsp_byte_count),
      .rsp_repeat_count(rsp_repeat_count),
      .rsp_status(rsp_status)
   );

   rle_symbol_decoder_unit_checker #(
      .MAX_SYMBOL_BYTES(MAX_BYTES)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_stream_start(req_stream_start),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_symbol_data(rsp_symbol_data),
      .rsp_byte_count(rsp_byte_count),
      .rsp_repeat_count(rsp_repeat_count),
      .rsp_status(rsp_status),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count),
      .symbol_count(symbol_count),
      .status_count(status_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                  QUIET_LIMIT, pending_count);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : receiver
      stall_mode_type mode;
      int mode_left;
      int run_left;
      mode = HOLD_NONE;
      mode_left = 0;
      run_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (want_long_hold && !long_hold_done) begin
            rsp_stall = 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_done = 1'b1;
            rsp_stall = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            case (mode)
               HOLD_NONE:     rsp_stall = 1'b0;
               HOLD_RANDOM:   rsp_stall = ($urandom_range(0, 2) == 0);
               HOLD_PERIODIC: rsp_stall = (mode_left % 4 == 0);
               default: begin
                  if (run_left == 0) begin
                     rsp_stall = !rsp_stall;
                     run_left = $urandom_range(1, 8);
                  end
                  run_left--;
               end
            endcase
         end
      end
   end

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // offer one request and hold it until accepted
   task automatic put_byte(input logic [7:0] b, input logic start, input bit live);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid = 1'b1;
      req_data_byte = b;
      req_stream_start = start;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
      if (live)
         live_bytes++;
   endtask

   task automatic put_signature(input int corrupt_at);
      logic [7:0] b;
      for (int i = 0; i < SIG_LEN; i++) begin
         b = sig_byte(4'(i));
         if (i == corrupt_at)
            b = b ^ 8'($urandom_range(1, 255));
         put_byte(b, 1'b0, 1'b1);
      end
   endtask

   task automatic put_group(input int size, input bit cut);
      int count;
      int total;
      if ($urandom_range(0, 9) == 0) begin
         put_byte(SKIP_CODE, 1'b0, 1'b1);
      end else begin
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 29))
               0:       count = (size == 1) ? $urandom_range(100, 127)
                                            : $urandom_range(5, 20);
               1, 2:    count = $urandom_range(5, 20);
               default: count = $urandom_range(1, 4);
            endcase
            put_byte(8'(count), 1'b0, 1'b1);
            total = count * size;
         end else begin
            count = $urandom_range(1, 127);
            put_byte(RUN_FLAG | 8'(count), 1'b0, 1'b1);
            total = size;
         end
         if (cut)
            total = $urandom_range(0, total - 1);
         repeat (total) put_byte(rand_byte(), 1'b0, 1'b1);
      end
   endtask

   function automatic int pick_size();
      case ($urandom_range(0, 9))
         0:       return MAX_BYTES;
         1, 2:    return $urandom_range(4, MAX_BYTES - 1);
         default: return $urandom_range(1, 3);
      endcase
   endfunction

   task automatic put_archive();
      int size;
      int groups;
      bit cut;
      size = pick_size();
      groups = $urandom_range(1, 6);
      cut = ($urandom_range(0, 6) == 0);
      put_byte(8'(size), 1'b1, 1'b1);
      put_signature(-1);
      for (int g = 0; g < groups; g++)
         put_group(size, cut && g == groups - 1);
      if (!cut && $urandom_range(0, 4) == 0) begin
         put_byte(RAW_CODE, 1'b0, 1'b1);
         repeat ($urandom_range(1, 12)) put_byte(rand_byte(), 1'b0, 1'b1);
      end
      archive_count++;
   endtask

   task automatic put_broken();
      case ($urandom_range(0, 3))
         0: put_byte(($urandom_range(0, 1) == 0) ? 8'd0
                     : 8'($urandom_range(MAX_BYTES + 1, 255)), 1'b1, 1'b1);
         1, 2: begin
            put_byte(8'(pick_size()), 1'b1, 1'b1);
            put_signature($urandom_range(0, SIG_LEN - 1));
         end
         default: ;
      endcase
      // drop into an idle or half-decoded decoder, occasionally restarting it
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(0, 3) == 0)
            put_byte(rand_byte(), 1'b1, 1'b1);
         else
            put_byte(rand_byte(), 1'b0, 1'b0);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'd0;
      req_stream_start = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // first archive without a stream start: repeat 127, literal, raw copy
      put_byte(8'd1, 1'b0, 1'b1);
      put_signature(-1);
      put_byte(SKIP_CODE, 1'b0, 1'b1);
      put_byte(RUN_FLAG | 8'd127, 1'b0, 1'b1);
      put_byte(8'hFF, 1'b0, 1'b1);
      put_byte(8'd1, 1'b0, 1'b1);
      put_byte(8'h00, 1'b0, 1'b1);
      put_byte(RAW_CODE, 1'b0, 1'b1);
      put_byte(8'h00, 1'b0, 1'b1);
      put_byte(8'hFF, 1'b0, 1'b1);
      // bad sizes at both ends, with an ignored byte between
      put_byte(8'd0, 1'b1, 1'b1);
      put_byte(8'h5A, 1'b0, 1'b0);
      put_byte(8'(MAX_BYTES + 1), 1'b1, 1'b1);
      put_byte(8'd255, 1'b1, 1'b1);

      // raw copy while the receiver holds off, so the decoder backs up
      put_byte(8'd1, 1'b1, 1'b1);
      put_signature(-1);
      put_byte(RAW_CODE, 1'b0, 1'b1);
      want_long_hold = 1'b1;
      repeat (60) put_byte(rand_byte(), 1'b0, 1'b1);

      while (live_bytes < RANDOM_BYTES) begin
         if ($urandom_range(0, 4) == 0)
            put_broken();
         else
            put_archive();
      end
      req_valid = 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Summary: %0d archive bytes in %0d well-formed archives plus broken ones",
               live_bytes, archive_count);
      $display("Summary: %0d symbol and %0d status results checked, %0d mismatches",
               symbol_count, status_count, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
